FILE: rtl/ccp_pkg.sv
// ----------------------------------------------------------------------------
// ccp_pkg: shared types and constants of the css color text parser
// character classes, parse phase codes, result format codes, result word
// ----------------------------------------------------------------------------
package ccp_pkg;

    localparam int COMP_BITS = 16;
    localparam int HEX_BITS  = 24;
    localparam int MAX_HEX   = 6;

    // parse phases
    localparam logic [3:0] PH_START   = 4'd0;
    localparam logic [3:0] PH_HEX     = 4'd1;
    localparam logic [3:0] PH_R       = 4'd2;
    localparam logic [3:0] PH_G       = 4'd3;
    localparam logic [3:0] PH_B       = 4'd4;
    localparam logic [3:0] PH_OPEN    = 4'd5;
    localparam logic [3:0] PH_NUM     = 4'd6;
    localparam logic [3:0] PH_BETWEEN = 4'd7;
    localparam logic [3:0] PH_DONE    = 4'd8;
    localparam logic [3:0] PH_FAIL    = 4'd9;

    // result formats
    localparam logic [1:0] FMT_HEX3 = 2'd0;
    localparam logic [1:0] FMT_HEX6 = 2'd1;
    localparam logic [1:0] FMT_INT  = 2'd2;
    localparam logic [1:0] FMT_PCT  = 2'd3;

    // characters
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        logic                 ok;
        logic [1:0]           format;
        logic [COMP_BITS-1:0] red;
        logic [COMP_BITS-1:0] green;
        logic [COMP_BITS-1:0] blue;
    } t_result;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

FILE: rtl/ccp_char_if.sv
// ----------------------------------------------------------------------------
// ccp_char_if: character channel
// one string byte per word, with a last-byte flag
// ----------------------------------------------------------------------------
interface ccp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_string;

    modport source (output valid, output char_code, output end_of_string, input ready);
    modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

FILE: rtl/ccp_result_if.sv
// ----------------------------------------------------------------------------
// ccp_result_if: result channel
// verdict, format and three color numerators per word
// ----------------------------------------------------------------------------
interface ccp_result_if
    import ccp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [1:0]           format;
    logic [COMP_BITS-1:0] red;
    logic [COMP_BITS-1:0] green;
    logic [COMP_BITS-1:0] blue;

    modport source (output valid, output ok, output format, output red, output green,
                    output blue, input ready);
    modport sink   (input valid, input ok, input format, input red, input green,
                    input blue, output ready);
endinterface

FILE: rtl/css_color_text_parser_top.sv
// a last character passes the input register, then the result register;
// throughput: one character word per cycle; a last one waits while the result
// register holds an untaken word; the state update is combinational logic
// reset: synchronous active-low i_rst_n returns the parser to string start
// and empties the input and result registers
// ----------------------------------------------------------------------------
// css_color_text_parser_top: streaming css color string checker
// input register, parse core and result register with valid/ready channels
// ----------------------------------------------------------------------------
module css_color_text_parser_top
    import ccp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    ccp_char_if.sink      i_char,
    ccp_result_if.source  o_result
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_end;
    logic       r_out_valid;
    t_result    r_out;
    t_result    core_result;
    logic       fire;

    // a non-final character never waits on the result side
    assign fire         = r_in_valid && (!r_in_end || !r_out_valid || o_result.ready);
    assign i_char.ready = !r_in_valid || fire;

    ccp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (fire),
        .i_char_code (r_in_char),
        .i_end       (r_in_end),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_in_char <= i_char.char_code;
            r_in_end  <= i_char.end_of_string;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in_end) begin
            r_out <= core_result;
        end
    end

    assign o_result.valid  = r_out_valid;
    assign o_result.ok     = r_out.ok;
    assign o_result.format = r_out.format;
    assign o_result.red    = r_out.red;
    assign o_result.green  = r_out.green;
    assign o_result.blue   = r_out.blue;

endmodule

FILE: rtl/ccp_core.sv
// ----------------------------------------------------------------------------
// ccp_core: parse state and per-character update
// holds the parser state, steps it by one character and forms the verdict
// ----------------------------------------------------------------------------
module ccp_core
    import ccp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_char_code,
    input  logic       i_end,
    output t_result    o_result
);

    logic [3:0]           r_phase, n_phase;
    logic [1:0]           r_idx, n_idx;
    logic [2:0]           r_cnt, n_cnt;
    logic [HEX_BITS-1:0]  r_hex, n_hex;
    logic [COMP_BITS-1:0] r_val [3];
    logic [COMP_BITS-1:0] n_val [3];
    logic                 r_pct, n_pct;
    logic                 r_comma, n_comma;

    logic [7:0]           c;
    logic                 c_dec;
    logic                 c_ws;
    logic [3:0]           dig;
    logic                 hex_ok;
    logic [3:0]           hex_dig;
    logic [COMP_BITS-1:0] cur;
    logic [COMP_BITS+3:0] acc;
    logic                 pct_new;
    logic                 do_between;
    logic [1:0]           idx_inc;

    assign c     = i_char_code;
    assign c_dec = is_dec(c);
    assign c_ws  = is_ws(c);
    assign dig   = c[3:0];
    assign cur   = r_val[r_idx];
    assign idx_inc = r_idx + 2'd1;

    // value * 10 + digit, saturating below
    assign acc = {1'b0, cur, 3'b000} + {3'b000, cur, 1'b0} + {{COMP_BITS{1'b0}}, dig};

    always_comb begin
        hex_ok  = 1'b1;
        hex_dig = dig;
        if (c_dec) begin
            hex_dig = dig;
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            hex_dig = c[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_hex      = r_hex;
        n_val      = r_val;
        n_pct      = r_pct;
        n_comma    = r_comma;
        pct_new    = r_pct;
        do_between = 1'b0;

        unique case (r_phase)
            PH_START: begin
                if (c == CH_HASH) n_phase = PH_HEX;
                else if (c == 8'h72 || c == 8'h52) n_phase = PH_R;
                else n_phase = PH_FAIL;
            end
            PH_HEX: begin
                if (!hex_ok || r_cnt >= 3'(MAX_HEX)) begin
                    n_phase = PH_FAIL;
                end else begin
                    n_hex = {r_hex[HEX_BITS-5:0], hex_dig};
                    n_cnt = r_cnt + 3'd1;
                end
            end
            PH_R: n_phase = (c == 8'h67 || c == 8'h47) ? PH_G : PH_FAIL;
            PH_G: n_phase = (c == 8'h62 || c == 8'h42) ? PH_B : PH_FAIL;
            PH_B: n_phase = (c == CH_LPAREN) ? PH_OPEN : PH_FAIL;
            PH_OPEN: begin
                if (c_dec) begin
                    n_val[r_idx] = {{(COMP_BITS-4){1'b0}}, dig};
                    n_phase      = PH_NUM;
                end else if (!c_ws) begin
                    n_phase = PH_FAIL;
                end
            end
            PH_NUM: begin
                if (c_dec) begin
                    if (acc[COMP_BITS+3:COMP_BITS] != 4'd0)
                        n_val[r_idx] = {COMP_BITS{1'b1}};
                    else
                        n_val[r_idx] = acc[COMP_BITS-1:0];
                end else begin
                    // the first value decides percent mode
                    if (r_idx == 2'd0) pct_new = (c == CH_PCT);
                    n_pct   = pct_new;
                    n_phase = PH_BETWEEN;
                    if (pct_new) begin
                        if (c != CH_PCT) n_phase = PH_FAIL;
                    end else if (c == CH_PCT) begin
                        n_phase = PH_FAIL;
                    end else begin
                        do_between = 1'b1;
                    end
                end
            end
            PH_BETWEEN: do_between = 1'b1;
            default:    n_phase = PH_FAIL;
        endcase

        if (do_between && !c_ws) begin
            if (c == CH_COMMA) begin
                if (r_comma || r_idx >= 2'd2) n_phase = PH_FAIL;
                else n_comma = 1'b1;
            end else if (c_dec && r_comma) begin
                n_comma        = 1'b0;
                n_idx          = idx_inc;
                n_val[idx_inc] = {{(COMP_BITS-4){1'b0}}, dig};
                n_phase        = PH_NUM;
            end else if (c == CH_RPAREN && !r_comma && r_idx == 2'd2) begin
                n_phase = PH_DONE;
            end else begin
                n_phase = PH_FAIL;
            end
        end
    end

    // verdict on the state after this character
    always_comb begin
        o_result = '0;
        if (n_phase == PH_HEX && n_cnt == 3'd3) begin
            o_result.ok     = 1'b1;
            o_result.format = FMT_HEX3;
            o_result.red    = {{(COMP_BITS-4){1'b0}}, n_hex[11:8]};
            o_result.green  = {{(COMP_BITS-4){1'b0}}, n_hex[7:4]};
            o_result.blue   = {{(COMP_BITS-4){1'b0}}, n_hex[3:0]};
        end else if (n_phase == PH_HEX && n_cnt == 3'(MAX_HEX)) begin
            o_result.ok     = 1'b1;
            o_result.format = FMT_HEX6;
            o_result.red    = {{(COMP_BITS-8){1'b0}}, n_hex[23:16]};
            o_result.green  = {{(COMP_BITS-8){1'b0}}, n_hex[15:8]};
            o_result.blue   = {{(COMP_BITS-8){1'b0}}, n_hex[7:0]};
        end else if (n_phase == PH_DONE) begin
            o_result.ok     = 1'b1;
            o_result.format = n_pct ? FMT_PCT : FMT_INT;
            o_result.red    = n_val[0];
            o_result.green  = n_val[1];
            o_result.blue   = n_val[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_end)) begin
            r_phase <= PH_START;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_hex   <= '0;
            r_val   <= '{default: '0};
            r_pct   <= 1'b0;
            r_comma <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_hex   <= n_hex;
            r_val   <= n_val;
            r_pct   <= n_pct;
            r_comma <= n_comma;
        end
    end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the css color text parser
// streams directed and random color strings, one character per word, into
// the parser under random source gaps and sink stalls, predicts each verdict
// in a local parse model and checks every result word field by field
// ----------------------------------------------------------------------------
module tb_top
    import ccp_pkg::*;
();

    localparam int TARGET_WORDS = 650;
    localparam int CALM_WORDS   = 80;
    localparam int LONG_HOLD    = 500;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_R  = 8'h52;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_UP_G  = 8'h47;
    localparam logic [7:0] CH_LO_G  = 8'h67;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [15:0] LEVEL_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_char_word;

    logic i_clk;
    logic i_rst_n;

    ccp_char_if   char_bus();
    ccp_result_if result_bus();

    css_color_text_parser_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_bus),
        .o_result (result_bus)
    );

    t_char_word pending_chars[$];
    logic [7:0] text_buf[$];
    t_result    expected_colors[$];
    string      hex_chars = "0123456789abcdefABCDEF";

    // local parse state
    logic [3:0]  phase_now;
    logic [1:0]  slot;
    logic [2:0]  nibble_cnt;
    logic [23:0] nibble_bits;
    logic [15:0] level [0:2];
    logic        pct_form;
    logic        comma_pending;
    logic        text_bad;

    int   mismatch_count;
    int   results_seen;
    int   gap_left;
    int   gap_odds;
    int   send_cycles;
    int   hold_left;
    int   hold_odds;
    int   sink_cycles;
    int   quiet_cycles;
    bit   long_hold_done;
    logic calm;

    // ------------------------------------------------------------------
    // parse model
    // ------------------------------------------------------------------
    function automatic logic blank_char(input logic [7:0] c);
        return c inside {CH_SPACE, [CH_TAB:CH_CR]};
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic int nibble_of(input logic [7:0] c);
        if (c inside {[CH_ZERO:CH_NINE]}) return int'(c - CH_ZERO);
        if (c inside {[CH_LO_A:CH_LO_F]}) return int'(c - CH_LO_A) + 10;
        if (c inside {[CH_UP_A:CH_UP_F]}) return int'(c - CH_UP_A) + 10;
        return -1;
    endfunction

    task automatic clear_parse();
        phase_now     = PH_START;
        slot          = '0;
        nibble_cnt    = '0;
        nibble_bits   = '0;
        level[0]      = '0;
        level[1]      = '0;
        level[2]      = '0;
        pct_form      = 1'b0;
        comma_pending = 1'b0;
        text_bad      = 1'b0;
    endtask

    task automatic go_bad();
        text_bad  = 1'b1;
        phase_now = PH_FAIL;
    endtask

    task automatic begin_level(input logic [7:0] c);
        if (slot > 2'd2) begin
            go_bad();
        end else begin
            level[slot] = {8'd0, c - CH_ZERO};
            phase_now   = PH_NUM;
        end
    endtask

    // separator region between two values, or before ')'
    task automatic take_gap_char(input logic [7:0] c);
        if (blank_char(c)) return;
        if (c == CH_COMMA) begin
            if (comma_pending || slot >= 2'd2) go_bad();
            else comma_pending = 1'b1;
        end else if (digit_char(c) && comma_pending) begin
            comma_pending = 1'b0;
            slot          = slot + 2'd1;
            begin_level(c);
        end else if (c == CH_RPAREN && !comma_pending && slot == 2'd2) begin
            phase_now = PH_DONE;
        end else begin
            go_bad();
        end
    endtask

    task automatic step_char(input logic [7:0] c);
        int          nib;
        logic [31:0] grown;
        case (phase_now)
            PH_START: begin
                if (c == CH_HASH) phase_now = PH_HEX;
                else if (c == CH_LO_R || c == CH_UP_R) phase_now = PH_R;
                else go_bad();
            end
            PH_HEX: begin
                nib = nibble_of(c);
                if (nib < 0 || nibble_cnt >= MAX_HEX) begin
                    go_bad();
                end else begin
                    nibble_bits = {nibble_bits[19:0], 4'(nib)};
                    nibble_cnt  = nibble_cnt + 3'd1;
                end
            end
            PH_R: begin
                if (c == CH_LO_G || c == CH_UP_G) phase_now = PH_G;
                else go_bad();
            end
            PH_G: begin
                if (c == CH_LO_B || c == CH_UP_B) phase_now = PH_B;
                else go_bad();
            end
            PH_B: begin
                if (c == CH_LPAREN) phase_now = PH_OPEN;
                else go_bad();
            end
            PH_OPEN: begin
                if (digit_char(c)) begin_level(c);
                else if (!blank_char(c)) go_bad();
            end
            PH_NUM: begin
                if (digit_char(c)) begin
                    grown = 32'(level[slot]) * 32'd10 + 32'(c - CH_ZERO);
                    level[slot] = (grown > 32'(LEVEL_MAX)) ? LEVEL_MAX : grown[15:0];
                end else begin
                    // the first value decides whether '%' is required
                    if (slot == 2'd0) pct_form = (c == CH_PCT);
                    phase_now = PH_BETWEEN;
                    if (pct_form) begin
                        if (c != CH_PCT) go_bad();
                    end else if (c == CH_PCT) begin
                        go_bad();
                    end else begin
                        take_gap_char(c);
                    end
                end
            end
            PH_BETWEEN: take_gap_char(c);
            default: go_bad();
        endcase
    endtask

    task automatic predict_color(input logic [7:0] c, input logic last);
        t_result verdict;
        step_char(c);
        if (last) begin
            verdict = '0;
            if (!text_bad && phase_now == PH_HEX && nibble_cnt == 3'd3) begin
                verdict.ok     = 1'b1;
                verdict.format = FMT_HEX3;
                verdict.red    = 16'(nibble_bits[11:8]);
                verdict.green  = 16'(nibble_bits[7:4]);
                verdict.blue   = 16'(nibble_bits[3:0]);
            end else if (!text_bad && phase_now == PH_HEX && nibble_cnt == 3'd6) begin
                verdict.ok     = 1'b1;
                verdict.format = FMT_HEX6;
                verdict.red    = 16'(nibble_bits[23:16]);
                verdict.green  = 16'(nibble_bits[15:8]);
                verdict.blue   = 16'(nibble_bits[7:0]);
            end else if (!text_bad && phase_now == PH_DONE) begin
                verdict.ok     = 1'b1;
                verdict.format = pct_form ? FMT_PCT : FMT_INT;
                verdict.red    = level[0];
                verdict.green  = level[1];
                verdict.blue   = level[2];
            end
            expected_colors = {expected_colors, verdict};
            clear_parse();
        end
    endtask

    // ------------------------------------------------------------------
    // string builders
    // ------------------------------------------------------------------
    function automatic logic [7:0] any_case(input logic [7:0] b);
        if ((b inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]}) && $urandom_range(0, 1) == 1)
            return b ^ CASE_BIT;
        return b;
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 2;
            default: return 8;
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] b);
        text_buf = {text_buf, b};
    endtask

    task automatic put_text(input string t, input bit mixed_case);
        int k;
        for (k = 0; k < t.len(); k++)
            put_byte(mixed_case ? any_case(t[k]) : t[k]);
    endtask

    task automatic put_blanks();
        int pick;
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                pick = $urandom_range(0, 5);
                put_byte((pick == 0) ? CH_SPACE : CH_TAB + 8'(pick - 1));
            end
        end
    endtask

    task automatic put_number();
        int len;
        // long runs can push the value past the saturation point
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
        repeat (len) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic make_hex(input int n);
        put_byte(CH_HASH);
        repeat (n) put_byte(hex_chars[$urandom_range(0, 21)]);
    endtask

    task automatic make_rgb(input bit pct, input int odd_slot);
        int k;
        put_text("rgb(", 1'b1);
        put_blanks();
        for (k = 0; k < 3; k++) begin
            if (k > 0) begin
                put_blanks();
                put_byte(CH_COMMA);
                put_blanks();
            end
            put_number();
            if (pct ^ (k == odd_slot)) put_byte(CH_PCT);
        end
        put_blanks();
        put_byte(CH_RPAREN);
    endtask

    task automatic damage_text();
        int commas[$];
        int k;
        int pos;
        for (k = 0; k < text_buf.size(); k++)
            if (text_buf[k] == CH_COMMA) commas = {commas, k};
        pos = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 7))
            0: text_buf[pos] = 8'($urandom_range(0, 255));
            1: text_buf.insert(pos, 8'($urandom_range(0, 255)));
            2: text_buf.delete(pos);
            3: while (text_buf.size() > pos + 1) void'(text_buf.pop_back());
            4: put_byte(8'($urandom_range(0, 255)));
            5: begin
                // doubled comma in one gap
                if (commas.size() != 0)
                    text_buf.insert(commas[$urandom_range(0, commas.size() - 1)], CH_COMMA);
                else
                    put_byte(CH_COMMA);
            end
            6: text_buf.insert(text_buf.size() - 1, CH_COMMA);
            default: begin
                if (commas.size() != 0)
                    text_buf.delete(commas[$urandom_range(0, commas.size() - 1)]);
                else
                    text_buf.insert(pos, CH_COMMA);
            end
        endcase
    endtask

    task automatic send_text();
        t_char_word w;
        int         k;
        if (text_buf.size() == 0) put_byte(8'($urandom_range(0, 255)));
        for (k = 0; k < text_buf.size(); k++) begin
            w.code = text_buf[k];
            w.last = (k == text_buf.size() - 1);
            pending_chars = {pending_chars, w};
        end
        text_buf.delete();
    endtask

    task automatic make_random_string();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            make_hex($urandom_range(0, 1) ? 6 : 3);
        end else if (pick < 28) begin
            // a digit count from zero to eight but three or six
            n = $urandom_range(0, 6);
            if (n >= 3) n++;
            if (n >= 6) n++;
            make_hex(n);
        end else if (pick < 68) begin
            make_rgb(1'($urandom_range(0, 1)), 3);
        end else if (pick < 76) begin
            make_rgb(1'($urandom_range(0, 1)), $urandom_range(0, 2));
        end else if (pick < 92) begin
            if ($urandom_range(0, 3) == 0) make_hex($urandom_range(0, 1) ? 6 : 3);
            else make_rgb(1'($urandom_range(0, 1)), 3);
            damage_text();
        end else begin
            case ($urandom_range(0, 2))
                0:       put_byte(CH_HASH);
                1:       put_text("rg", 1'b1);
                default: ;
            endcase
            repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(0, 255)));
        end
        send_text();
    endtask

    // ------------------------------------------------------------------
    // clock, reset, stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n                = 1'b0;
        char_bus.valid         = 1'b0;
        char_bus.char_code     = '0;
        char_bus.end_of_string = 1'b0;
        result_bus.ready       = 1'b0;
        calm                   = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        clear_parse();
        mismatch_count = 0;
        results_seen   = 0;
        long_hold_done = 1'b0;

        put_text("#0aF", 1'b0);
        send_text();
        put_text("#Ff09aB", 1'b0);
        send_text();
        put_text("rGb(99999,0 ,7)", 1'b0);
        send_text();
        put_byte(8'hFF);
        send_text();
        put_byte(8'h00);
        send_text();
        while (pending_chars.size() < TARGET_WORDS) make_random_string();

        @(negedge i_clk);
        while (pending_chars.size() != 0 || char_bus.valid) @(negedge i_clk);
        while (expected_colors.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // character driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_char_word w;
        if (!i_rst_n) begin
            char_bus.valid         <= 1'b0;
            char_bus.char_code     <= '0;
            char_bus.end_of_string <= 1'b0;
            gap_left    = 0;
            gap_odds    = 0;
            send_cycles = 0;
        end else begin
            if (char_bus.valid && char_bus.ready)
                predict_color(char_bus.char_code, char_bus.end_of_string);
            send_cycles++;
            if (send_cycles % 97 == 0) gap_odds = pick_odds();
            calm <= (pending_chars.size() < CALM_WORDS);
            if (!char_bus.valid || char_bus.ready) begin
                if (gap_left > 0 && !calm) begin
                    gap_left--;
                    char_bus.valid <= 1'b0;
                end else if (pending_chars.size() != 0) begin
                    w = pending_chars.pop_front();
                    char_bus.char_code     <= w.code;
                    char_bus.end_of_string <= w.last;
                    char_bus.valid         <= 1'b1;
                    gap_left = 0;
                    if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
                        gap_left = $urandom_range(1, 17);
                end else begin
                    char_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and sink
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
            hold_left   = 0;
            hold_odds   = 0;
            sink_cycles = 0;
        end else begin
            if (result_bus.valid && result_bus.ready) begin
                results_seen++;
                if (expected_colors.size() == 0) begin
                    $display("%0t: result word with none pending: ok %0d format %0d rgb %0d %0d %0d",
                             $time, result_bus.ok, result_bus.format, result_bus.red,
                             result_bus.green, result_bus.blue);
                    mismatch_count++;
                end else begin
                    want = expected_colors.pop_front();
                    if (result_bus.ok !== want.ok) begin
                        $display("%0t: ok expected %0d got %0d", $time, want.ok, result_bus.ok);
                        mismatch_count++;
                    end
                    if (result_bus.format !== want.format) begin
                        $display("%0t: format expected %0d got %0d",
                                 $time, want.format, result_bus.format);
                        mismatch_count++;
                    end
                    if (result_bus.red !== want.red) begin
                        $display("%0t: red expected %0d got %0d", $time, want.red, result_bus.red);
                        mismatch_count++;
                    end
                    if (result_bus.green !== want.green) begin
                        $display("%0t: green expected %0d got %0d",
                                 $time, want.green, result_bus.green);
                        mismatch_count++;
                    end
                    if (result_bus.blue !== want.blue) begin
                        $display("%0t: blue expected %0d got %0d",
                                 $time, want.blue, result_bus.blue);
                        mismatch_count++;
                    end
                end
            end
            sink_cycles++;
            if (sink_cycles % 131 == 0) hold_odds = pick_odds();
            if (hold_left > 0 && !calm) begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end else if (!calm && !long_hold_done && results_seen >= 20) begin
                // long back-pressure so the parser fills and stops taking characters
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
                result_bus.ready <= 1'b0;
            end else if (!calm && hold_odds != 0 && $urandom_range(0, hold_odds) == 0) begin
                hold_left = $urandom_range(0, 16);
                result_bus.ready <= 1'b0;
            end else begin
                hold_left = 0;
                result_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (char_bus.valid && char_bus.ready)
            || (result_bus.valid && result_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

FILE: sim.f
rtl/ccp_pkg.sv
rtl/ccp_char_if.sv
rtl/ccp_result_if.sv
rtl/ccp_core.sv
rtl/css_color_text_parser_top.sv
dv/tb_top.sv
